// ===== src/podavg_pkg.sv =====
`default_nettype none

package podavg_pkg;

    localparam int SEC_W          = 32;
    localparam int USEC_W         = 20;
    localparam int DS_W           = 35;
    localparam int DU_W           = 23;
    localparam int TOT_W          = 56;
    localparam int RES_W          = 32;
    localparam int SUM_W          = 40;
    localparam int USEC_PER_SEC   = 1000000;
    localparam int DEFAULT_WINDOW = 10;
    localparam int RECIP_SHIFT    = 40;
    localparam int CDIV_LAT       = 5;

    typedef enum logic [1:0] {
        CMD_SYNC   = 2'd0,
        CMD_FOLLOW = 2'd1,
        CMD_IGNORE = 2'd2,
        CMD_DRESP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_REQ    = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_AVG    = 2'd2
    } kind_t;

    typedef logic signed [RES_W-1:0] sword_t;

    typedef struct packed {
        logic valid;
        logic report;
    } podavg_ctl_t;

    typedef struct packed {
        kind_t  kind;
        sword_t offset_us;
        sword_t delay_us;
        sword_t avg_offset_us;
        sword_t avg_delay_us;
    } podavg_word_t;

endpackage

`default_nettype wire

// ===== src/podavg_front.sv =====
`default_nettype none

module podavg_front
    import podavg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              in_accept,
    input  wire logic [1:0]        command,
    input  wire logic [SEC_W-1:0]  local_sec,
    input  wire logic [USEC_W-1:0] local_usec,
    input  wire logic [SEC_W-1:0]  remote_sec,
    input  wire logic [USEC_W-1:0] remote_usec,
    output podavg_ctl_t            ctl,
    output sword_t                 off,
    output sword_t                 dly
);

    localparam logic signed [TOT_W-1:0] SAT_MAX = TOT_W'(64'sh7fffffff);
    localparam logic signed [TOT_W-1:0] SAT_MIN = TOT_W'(-64'sh80000000);

    function automatic logic signed [DS_W-1:0] sec_diff(
        input logic [SEC_W-1:0] a,
        input logic [SEC_W-1:0] b,
        input logic [SEC_W-1:0] c,
        input logic [SEC_W-1:0] d
    );
        return $signed(DS_W'(a) + DS_W'(b) - DS_W'(c) - DS_W'(d));
    endfunction

    function automatic logic signed [DU_W-1:0] usec_diff(
        input logic [USEC_W-1:0] a,
        input logic [USEC_W-1:0] b,
        input logic [USEC_W-1:0] c,
        input logic [USEC_W-1:0] d
    );
        return $signed(DU_W'(a) + DU_W'(b) - DU_W'(c) - DU_W'(d));
    endfunction

    // Halve with truncation toward zero, then clamp to the 32-bit signed range.
    function automatic sword_t half_sat(input logic signed [TOT_W-1:0] t);
        logic signed [TOT_W-1:0] h;
        h = (t + $signed({{(TOT_W-1){1'b0}}, t[TOT_W-1]})) >>> 1;
        if (h > SAT_MAX) begin
            return SAT_MAX[RES_W-1:0];
        end
        if (h < SAT_MIN) begin
            return SAT_MIN[RES_W-1:0];
        end
        return h[RES_W-1:0];
    endfunction

    cmd_t cmd;

    logic [SEC_W-1:0]  t0_sec_reg;
    logic [USEC_W-1:0] t0_usec_reg;
    logic [SEC_W-1:0]  t1_sec_reg;
    logic [USEC_W-1:0] t1_usec_reg;
    logic [SEC_W-1:0]  t2_sec_reg;
    logic [USEC_W-1:0] t2_usec_reg;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_report_reg;
    logic                    s1_report_next;
    logic signed [DS_W-1:0]  s1_soff_reg;
    logic signed [DS_W-1:0]  s1_soff_next;
    logic signed [DU_W-1:0]  s1_uoff_reg;
    logic signed [DU_W-1:0]  s1_uoff_next;
    logic signed [DS_W-1:0]  s1_sdly_reg;
    logic signed [DS_W-1:0]  s1_sdly_next;
    logic signed [DU_W-1:0]  s1_udly_reg;
    logic signed [DU_W-1:0]  s1_udly_next;

    logic                    s2_valid_reg;
    logic                    s2_report_reg;
    logic signed [TOT_W-1:0] s2_toff_reg;
    logic signed [TOT_W-1:0] s2_toff_next;
    logic signed [TOT_W-1:0] s2_tdly_reg;
    logic signed [TOT_W-1:0] s2_tdly_next;

    logic                    s3_valid_reg;
    logic                    s3_report_reg;
    sword_t                  s3_off_reg;
    sword_t                  s3_off_next;
    sword_t                  s3_dly_reg;
    sword_t                  s3_dly_next;

    assign cmd = cmd_t'(command);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_sec_reg  <= '0;
            t0_usec_reg <= '0;
            t1_sec_reg  <= '0;
            t1_usec_reg <= '0;
            t2_sec_reg  <= '0;
            t2_usec_reg <= '0;
        end
        else if (in_accept)
        begin
            unique case (cmd)
                CMD_SYNC:
                begin
                    t1_sec_reg  <= local_sec;
                    t1_usec_reg <= local_usec;
                end
                CMD_FOLLOW:
                begin
                    t0_sec_reg  <= remote_sec;
                    t0_usec_reg <= remote_usec;
                    t2_sec_reg  <= local_sec;
                    t2_usec_reg <= local_usec;
                end
                CMD_IGNORE:
                begin
                end
                CMD_DRESP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next  = in_accept && (cmd == CMD_FOLLOW || cmd == CMD_DRESP);
        s1_report_next = (cmd == CMD_DRESP);
        s1_soff_next   = sec_diff(t1_sec_reg, t2_sec_reg, t0_sec_reg, remote_sec);
        s1_uoff_next   = usec_diff(t1_usec_reg, t2_usec_reg, t0_usec_reg, remote_usec);
        s1_sdly_next   = sec_diff(t1_sec_reg, remote_sec, t0_sec_reg, t2_sec_reg);
        s1_udly_next   = usec_diff(t1_usec_reg, remote_usec, t0_usec_reg, t2_usec_reg);
    end

    always_comb
    begin
        s2_toff_next = TOT_W'(s1_soff_reg) * TOT_W'(USEC_PER_SEC) + TOT_W'(s1_uoff_reg);
        s2_tdly_next = TOT_W'(s1_sdly_reg) * TOT_W'(USEC_PER_SEC) + TOT_W'(s1_udly_reg);
    end

    always_comb
    begin
        s3_off_next = s2_report_reg ? half_sat(s2_toff_reg) : '0;
        s3_dly_next = s2_report_reg ? half_sat(s2_tdly_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_report_reg <= s1_report_next;
            s1_soff_reg   <= s1_soff_next;
            s1_uoff_reg   <= s1_uoff_next;
            s1_sdly_reg   <= s1_sdly_next;
            s1_udly_reg   <= s1_udly_next;
            s2_report_reg <= s1_report_reg;
            s2_toff_reg   <= s2_toff_next;
            s2_tdly_reg   <= s2_tdly_next;
            s3_report_reg <= s2_report_reg;
            s3_off_reg    <= s3_off_next;
            s3_dly_reg    <= s3_dly_next;
        end
    end

    assign ctl.valid  = s3_valid_reg;
    assign ctl.report = s3_report_reg;
    assign off        = s3_off_reg;
    assign dly        = s3_dly_reg;

endmodule

`default_nettype wire

// ===== src/podavg_cdiv.sv =====
`default_nettype none

module podavg_cdiv
    import podavg_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  wire logic                    clk,
    input  wire logic                    advance,
    input  wire logic signed [SUM_W-1:0] dividend,
    output sword_t                       quotient
);

    localparam int HALF_W = SUM_W / 2;
    localparam int RLO_W  = RECIP_SHIFT + 1 - HALF_W;
    localparam int PROD_W = SUM_W + RECIP_SHIFT + 1;

    localparam logic [63:0]          RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(WINDOW);
    localparam logic [RECIP_SHIFT:0] RECIP      = RECIP_FULL[RECIP_SHIFT:0];
    localparam logic [RLO_W-1:0]     RECIP_LO   = RECIP[RLO_W-1:0];
    localparam logic [HALF_W-1:0]    RECIP_HI   = RECIP[RECIP_SHIFT:RLO_W];
    localparam logic [SUM_W-1:0]     DIVISOR    = SUM_W'(WINDOW);

    logic                       neg_a_reg;
    logic [SUM_W-1:0]           mag_a_reg;
    logic [SUM_W-1:0]           mag_a_next;

    logic                       neg_b_reg;
    logic [SUM_W-1:0]           mag_b_reg;
    logic [HALF_W+RLO_W-1:0]    pp_ll_reg;
    logic [HALF_W+HALF_W-1:0]   pp_lh_reg;
    logic [HALF_W+RLO_W-1:0]    pp_hl_reg;
    logic [HALF_W+HALF_W-1:0]   pp_hh_reg;

    logic [PROD_W-1:0]          prod_sum;
    logic                       neg_c_reg;
    logic [SUM_W-1:0]           mag_c_reg;
    logic [RES_W-1:0]           q0_c_reg;

    logic                       neg_d_reg;
    logic [SUM_W-1:0]           mag_d_reg;
    logic [RES_W-1:0]           q0_d_reg;
    logic [SUM_W-1:0]           qw_d_reg;
    logic [SUM_W-1:0]           qw_d_next;

    logic [SUM_W-1:0]           rem;
    logic [RES_W-1:0]           q_mag;
    sword_t                     quotient_reg;
    sword_t                     quotient_next;

    // The reciprocal estimate is low by at most one; the remainder check repairs it.
    always_comb
    begin
        mag_a_next = dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
        prod_sum   = PROD_W'(pp_ll_reg)
                   + (PROD_W'(pp_lh_reg) << RLO_W)
                   + (PROD_W'(pp_hl_reg) << HALF_W)
                   + (PROD_W'(pp_hh_reg) << (RLO_W + HALF_W));
        qw_d_next  = SUM_W'(q0_c_reg) * DIVISOR;
        rem        = mag_d_reg - qw_d_reg;
        q_mag      = q0_d_reg + ((rem >= DIVISOR) ? RES_W'(1) : RES_W'(0));
        quotient_next = neg_d_reg ? -$signed(q_mag) : $signed(q_mag);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            neg_a_reg    <= dividend[SUM_W-1];
            mag_a_reg    <= mag_a_next;

            neg_b_reg    <= neg_a_reg;
            mag_b_reg    <= mag_a_reg;
            pp_ll_reg    <= mag_a_reg[HALF_W-1:0] * RECIP_LO;
            pp_lh_reg    <= mag_a_reg[HALF_W-1:0] * RECIP_HI;
            pp_hl_reg    <= mag_a_reg[SUM_W-1:HALF_W] * RECIP_LO;
            pp_hh_reg    <= mag_a_reg[SUM_W-1:HALF_W] * RECIP_HI;

            neg_c_reg    <= neg_b_reg;
            mag_c_reg    <= mag_b_reg;
            q0_c_reg     <= prod_sum[RECIP_SHIFT +: RES_W];

            neg_d_reg    <= neg_c_reg;
            mag_d_reg    <= mag_c_reg;
            q0_d_reg     <= q0_c_reg;
            qw_d_reg     <= qw_d_next;

            quotient_reg <= quotient_next;
        end
    end

    assign quotient = quotient_reg;

endmodule

`default_nettype wire

// ===== src/podavg_window.sv =====
`default_nettype none

module podavg_window
    import podavg_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  podavg_ctl_t ctl,
    input  sword_t     off,
    input  sword_t     dly,
    output logic       out_valid,
    output podavg_word_t out_word
);

    localparam int               CNT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(WINDOW - 1);

    logic signed [SUM_W-1:0] offset_sum_reg;
    logic signed [SUM_W-1:0] offset_sum_next;
    logic signed [SUM_W-1:0] delay_sum_reg;
    logic signed [SUM_W-1:0] delay_sum_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic signed [SUM_W-1:0] offset_acc;
    logic signed [SUM_W-1:0] delay_acc;
    logic                    last;
    kind_t                   kind_next;

    logic [CDIV_LAT-1:0]     dl_valid_reg;
    kind_t                   dl_kind_reg [CDIV_LAT];
    sword_t                  dl_off_reg  [CDIV_LAT];
    sword_t                  dl_dly_reg  [CDIV_LAT];

    sword_t                  avg_off;
    sword_t                  avg_dly;
    kind_t                   tail_kind;

    always_comb
    begin
        offset_acc      = offset_sum_reg + SUM_W'(off);
        delay_acc       = delay_sum_reg + SUM_W'(dly);
        last            = (count_reg == LAST_COUNT);
        offset_sum_next = offset_sum_reg;
        delay_sum_next  = delay_sum_reg;
        count_next      = count_reg;
        kind_next       = KIND_REQ;
        if (ctl.valid && ctl.report)
        begin
            if (last)
            begin
                offset_sum_next = '0;
                delay_sum_next  = '0;
                count_next      = '0;
                kind_next       = KIND_AVG;
            end
            else
            begin
                offset_sum_next = offset_acc;
                delay_sum_next  = delay_acc;
                count_next      = count_reg + CNT_W'(1);
                kind_next       = KIND_REPORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_sum_reg <= '0;
            delay_sum_reg  <= '0;
            count_reg      <= '0;
            dl_valid_reg   <= '0;
        end
        else if (advance)
        begin
            offset_sum_reg <= offset_sum_next;
            delay_sum_reg  <= delay_sum_next;
            count_reg      <= count_next;
            dl_valid_reg   <= {dl_valid_reg[CDIV_LAT-2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dl_kind_reg[0] <= kind_next;
            dl_off_reg[0]  <= off;
            dl_dly_reg[0]  <= dly;
            for (int i = 1; i < CDIV_LAT; i++)
            begin
                dl_kind_reg[i] <= dl_kind_reg[i-1];
                dl_off_reg[i]  <= dl_off_reg[i-1];
                dl_dly_reg[i]  <= dl_dly_reg[i-1];
            end
        end
    end

    podavg_cdiv #(
        .WINDOW (WINDOW)
    ) u_cdiv_off (
        .clk      (clk),
        .advance  (advance),
        .dividend (offset_acc),
        .quotient (avg_off)
    );

    podavg_cdiv #(
        .WINDOW (WINDOW)
    ) u_cdiv_dly (
        .clk      (clk),
        .advance  (advance),
        .dividend (delay_acc),
        .quotient (avg_dly)
    );

    assign tail_kind = dl_kind_reg[CDIV_LAT-1];
    assign out_valid = dl_valid_reg[CDIV_LAT-1];

    always_comb
    begin
        out_word.kind          = tail_kind;
        out_word.offset_us     = dl_off_reg[CDIV_LAT-1];
        out_word.delay_us      = dl_dly_reg[CDIV_LAT-1];
        out_word.avg_offset_us = (tail_kind == KIND_AVG) ? avg_off : '0;
        out_word.avg_delay_us  = (tail_kind == KIND_AVG) ? avg_dly : '0;
    end

endmodule

`default_nettype wire

// ===== src/podavg_skid.sv =====
`default_nettype none

module podavg_skid
    import podavg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  podavg_word_t in_word,
    input  wire logic    out_ready,
    output logic         advance,
    output logic         out_valid,
    output podavg_word_t out_word
);

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    podavg_word_t out_word_reg;
    podavg_word_t out_word_next;
    podavg_word_t skid_word_reg;
    podavg_word_t skid_word_next;

    // The pipeline moves only while the spare slot is empty.
    assign advance = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_next = in_valid;
            out_word_next  = in_word;
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ===== src/ptp_offset_delay_averager_top.sv =====
// Clock offset and path delay engine for the server side of a four-timestamp
// sync exchange. Input words carry a command and two timestamps. A sync word
// stores the local arrival time, a follow-up word stores the client send time
// and the local time and yields a delay-request result, and a delay-response
// word yields a report of offset and delay in microseconds. Every WINDOW-th
// report also carries the window means. Sync and ignored words yield nothing.
// Both channels use valid and ready; a word moves when both are high.
// The difference stage loads at the edge that accepts an input word; the
// result then passes the multiply and saturation stages, the five-stage
// constant divider for the window means and the output register.
// One word is accepted every cycle while in_ready is high, so the throughput
// is one word per cycle while the output is not stalled.
// When the receiver stalls, a spare output slot takes one more result while
// input is still accepted; once that slot is full, in_ready drops and the
// whole pipeline holds until out_ready returns.
// Reset clears the stored timestamps, the window sums and the sample count to
// zero and empties the pipeline; there is no clearing pass after reset.
`default_nettype none

module ptp_offset_delay_averager_top
    import podavg_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [SEC_W-1:0]  local_sec,
    input  wire logic [USEC_W-1:0] local_usec,
    input  wire logic [SEC_W-1:0]  remote_sec,
    input  wire logic [USEC_W-1:0] remote_usec,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             result_kind,
    output logic signed [RES_W-1:0] offset_us,
    output logic signed [RES_W-1:0] delay_us,
    output logic signed [RES_W-1:0] avg_offset_us,
    output logic signed [RES_W-1:0] avg_delay_us
);

    logic         advance;
    logic         in_accept;
    podavg_ctl_t  front_ctl;
    sword_t       front_off;
    sword_t       front_dly;
    logic         win_valid;
    podavg_word_t win_word;
    podavg_word_t res_word;

    assign in_ready  = advance;
    assign in_accept = in_valid && advance;

    podavg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_accept   (in_accept),
        .command     (command),
        .local_sec   (local_sec),
        .local_usec  (local_usec),
        .remote_sec  (remote_sec),
        .remote_usec (remote_usec),
        .ctl         (front_ctl),
        .off         (front_off),
        .dly         (front_dly)
    );

    podavg_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl       (front_ctl),
        .off       (front_off),
        .dly       (front_dly),
        .out_valid (win_valid),
        .out_word  (win_word)
    );

    podavg_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_word   (win_word),
        .out_ready (out_ready),
        .advance   (advance),
        .out_valid (out_valid),
        .out_word  (res_word)
    );

    assign result_kind   = res_word.kind;
    assign offset_us     = res_word.offset_us;
    assign delay_us      = res_word.delay_us;
    assign avg_offset_us = res_word.avg_offset_us;
    assign avg_delay_us  = res_word.avg_delay_us;

endmodule

`default_nettype wire

// ===== src/podavg_chk.sv =====
`default_nettype none

module podavg_chk
    import podavg_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [1:0]        command,
    input wire logic [SEC_W-1:0]  local_sec,
    input wire logic [USEC_W-1:0] local_usec,
    input wire logic [SEC_W-1:0]  remote_sec,
    input wire logic [USEC_W-1:0] remote_usec,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [1:0]        result_kind,
    input wire logic [RES_W-1:0]  offset_us,
    input wire logic [RES_W-1:0]  delay_us,
    input wire logic [RES_W-1:0]  avg_offset_us,
    input wire logic [RES_W-1:0]  avg_delay_us
);

    // A delay request carries no measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_REQ |->
            offset_us == '0 && delay_us == '0 && avg_offset_us == '0 && avg_delay_us == '0)
    else $error("delay request word carries nonzero values");

    // Means are only reported at the end of a window.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_REPORT |-> avg_offset_us == '0 && avg_delay_us == '0)
    else $error("plain report carries nonzero window means");

    // Input is refused only while a finished word is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with an empty output");

    // A stalled output word is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(result_kind) && $stable(offset_us) && $stable(delay_us))
    else $error("stalled output word changed");

endmodule

bind ptp_offset_delay_averager_top podavg_chk u_podavg_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import podavg_pkg::*;

    localparam int AVG_LEN   = DEFAULT_WINDOW;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_WAIT = 24;
    localparam int MAX_PRINT = 60;

    localparam logic [SEC_W-1:0]  SEC_TOP   = 32'hFFFF_FFFF;
    localparam logic [USEC_W-1:0] USEC_TOP  = 20'hF_FFFF;
    localparam logic [USEC_W-1:0] USEC_LAST = 20'd999999;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } idle_t;

    typedef struct {
        cmd_t              cmd;
        logic [SEC_W-1:0]  lsec;
        logic [USEC_W-1:0] lusec;
        logic [SEC_W-1:0]  rsec;
        logic [USEC_W-1:0] rusec;
    } sync_word_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [1:0]        command     = CMD_IGNORE;
    logic [SEC_W-1:0]  local_sec   = '0;
    logic [USEC_W-1:0] local_usec  = '0;
    logic [SEC_W-1:0]  remote_sec  = '0;
    logic [USEC_W-1:0] remote_usec = '0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [1:0]        result_kind;
    logic signed [RES_W-1:0] offset_us;
    logic signed [RES_W-1:0] delay_us;
    logic signed [RES_W-1:0] avg_offset_us;
    logic signed [RES_W-1:0] avg_delay_us;

    sync_word_t   pending_words[$];
    podavg_word_t sync_results_due[$];

    int    words_queued = 0;
    int    err_count    = 0;
    idle_t send_style   = IDLE_NONE;
    idle_t recv_style   = IDLE_NONE;
    logic  hold_req     = 1'b0;
    logic  hold_done    = 1'b0;
    int    send_gap     = 0;
    int    recv_gap     = 0;
    int    hold_left    = 0;
    logic  drive_valid;
    logic  take_ready;

    logic [SEC_W-1:0]  t0_sec  = '0;
    logic [USEC_W-1:0] t0_usec = '0;
    logic [SEC_W-1:0]  t1_sec  = '0;
    logic [USEC_W-1:0] t1_usec = '0;
    logic [SEC_W-1:0]  t2_sec  = '0;
    logic [USEC_W-1:0] t2_usec = '0;
    longint            offset_acc  = 0;
    longint            delay_acc   = 0;
    int                window_fill = 0;

    ptp_offset_delay_averager_top #(
        .WINDOW(AVG_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .local_sec    (local_sec),
        .local_usec   (local_usec),
        .remote_sec   (remote_sec),
        .remote_usec  (remote_usec),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .offset_us    (offset_us),
        .delay_us     (delay_us),
        .avg_offset_us(avg_offset_us),
        .avg_delay_us (avg_delay_us)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (err_count < MAX_PRINT)
            $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic sword_t clamp_word(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return sword_t'(v[31:0]);
    endfunction

    function automatic sword_t half_span(
        input logic [SEC_W-1:0] p1_s, input logic [USEC_W-1:0] p1_u,
        input logic [SEC_W-1:0] p2_s, input logic [USEC_W-1:0] p2_u,
        input logic [SEC_W-1:0] m1_s, input logic [USEC_W-1:0] m1_u,
        input logic [SEC_W-1:0] m2_s, input logic [USEC_W-1:0] m2_u
    );
        longint sec_diff;
        longint usec_diff;
        longint total;
        sec_diff = longint'({32'd0, p1_s}) + longint'({32'd0, p2_s})
                 - longint'({32'd0, m1_s}) - longint'({32'd0, m2_s});
        usec_diff = longint'({44'd0, p1_u}) + longint'({44'd0, p2_u})
                  - longint'({44'd0, m1_u}) - longint'({44'd0, m2_u});
        total = sec_diff * longint'(USEC_PER_SEC) + usec_diff;
        return clamp_word(total / 2);
    endfunction

    task automatic predict_exchange(
        input cmd_t cmd,
        input logic [SEC_W-1:0] ls, input logic [USEC_W-1:0] lu,
        input logic [SEC_W-1:0] rs, input logic [USEC_W-1:0] ru
    );
        podavg_word_t res;
        res = '0;
        case (cmd)
            CMD_SYNC:
            begin
                t1_sec  = ls;
                t1_usec = lu;
            end
            CMD_FOLLOW:
            begin
                t0_sec   = rs;
                t0_usec  = ru;
                t2_sec   = ls;
                t2_usec  = lu;
                res.kind = KIND_REQ;
                sync_results_due.push_back(res);
            end
            CMD_DRESP:
            begin
                res.kind      = KIND_REPORT;
                res.offset_us = half_span(t1_sec, t1_usec, t2_sec, t2_usec,
                                          t0_sec, t0_usec, rs, ru);
                res.delay_us  = half_span(t1_sec, t1_usec, rs, ru,
                                          t0_sec, t0_usec, t2_sec, t2_usec);
                offset_acc += longint'(res.offset_us);
                delay_acc  += longint'(res.delay_us);
                if (window_fill + 1 >= AVG_LEN)
                begin
                    res.kind          = KIND_AVG;
                    res.avg_offset_us = clamp_word(offset_acc / longint'(AVG_LEN));
                    res.avg_delay_us  = clamp_word(delay_acc / longint'(AVG_LEN));
                    offset_acc  = 0;
                    delay_acc   = 0;
                    window_fill = 0;
                end
                else
                begin
                    window_fill++;
                end
                sync_results_due.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int draw_gap(input idle_t style);
        if (style == IDLE_NONE)
            return 0;
        if (style == IDLE_LIGHT && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            drive_valid = in_valid;
            if (in_valid && in_ready)
            begin
                predict_exchange(cmd_t'(command), local_sec, local_usec,
                                 remote_sec, remote_usec);
                pending_words.delete(0);
                drive_valid = 1'b0;
                send_gap = draw_gap(send_style);
            end
            if (!drive_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_words.size() != 0)
                begin
                    command     <= pending_words[0].cmd;
                    local_sec   <= pending_words[0].lsec;
                    local_usec  <= pending_words[0].lusec;
                    remote_sec  <= pending_words[0].rsec;
                    remote_usec <= pending_words[0].rusec;
                    drive_valid = 1'b1;
                end
            end
            in_valid <= drive_valid;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sync_results_due.size() == 0)
                begin
                    flag_error($sformatf("result with nothing expected, kind %0d",
                                         result_kind));
                end
                else
                begin
                    if (result_kind !== sync_results_due[0].kind)
                        flag_error($sformatf("result_kind %0d, want %0d", result_kind,
                                             sync_results_due[0].kind));
                    if (offset_us !== sync_results_due[0].offset_us)
                        flag_error($sformatf("offset_us %0d, want %0d", offset_us,
                                             sync_results_due[0].offset_us));
                    if (delay_us !== sync_results_due[0].delay_us)
                        flag_error($sformatf("delay_us %0d, want %0d", delay_us,
                                             sync_results_due[0].delay_us));
                    if (avg_offset_us !== sync_results_due[0].avg_offset_us)
                        flag_error($sformatf("avg_offset_us %0d, want %0d", avg_offset_us,
                                             sync_results_due[0].avg_offset_us));
                    if (avg_delay_us !== sync_results_due[0].avg_delay_us)
                        flag_error($sformatf("avg_delay_us %0d, want %0d", avg_delay_us,
                                             sync_results_due[0].avg_delay_us));
                    sync_results_due.delete(0);
                end
                recv_gap = draw_gap(recv_style);
            end
            if (hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done <= 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                take_ready = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                take_ready = 1'b0;
            end
            else
            begin
                take_ready = 1'b1;
            end
            out_ready <= take_ready;
        end
    end

    task automatic queue_word(
        input cmd_t cmd,
        input logic [SEC_W-1:0] ls, input logic [USEC_W-1:0] lu,
        input logic [SEC_W-1:0] rs, input logic [USEC_W-1:0] ru
    );
        sync_word_t w;
        w.cmd   = cmd;
        w.lsec  = ls;
        w.lusec = lu;
        w.rsec  = rs;
        w.rusec = ru;
        pending_words.push_back(w);
        if (cmd != CMD_IGNORE)
            words_queued++;
    endtask

    function automatic logic [USEC_W-1:0] rnd_usec(input logic full_range);
        if (full_range)
            return USEC_W'($urandom_range(0, (1 << USEC_W) - 1));
        return USEC_W'($urandom_range(0, 999999));
    endfunction

    function automatic logic [SEC_W-1:0] stamp_sec(input logic [SEC_W-1:0] base,
                                                   input int span_sel);
        if (span_sel == 9)
            return $urandom;
        if (span_sel < 7)
            return base + $urandom_range(0, 1);
        return base + $urandom_range(0, 4000);
    endfunction

    task automatic queue_noise();
        queue_word(cmd_t'($urandom_range(0, 3)), $urandom, rnd_usec(1'($urandom_range(0, 1))),
                   $urandom, rnd_usec(1'($urandom_range(0, 1))));
    endtask

    task automatic queue_exchange();
        int               span_sel;
        logic             full_usec;
        logic [SEC_W-1:0] base;
        span_sel  = $urandom_range(0, 9);
        full_usec = (span_sel == 9);
        base      = $urandom;
        queue_word(CMD_SYNC, stamp_sec(base, span_sel), rnd_usec(full_usec),
                   $urandom, rnd_usec(1'b1));
        if ($urandom_range(0, 7) == 0)
            queue_word(CMD_IGNORE, $urandom, rnd_usec(1'b1), $urandom, rnd_usec(1'b1));
        queue_word(CMD_FOLLOW, stamp_sec(base, span_sel), rnd_usec(full_usec),
                   stamp_sec(base, span_sel), rnd_usec(full_usec));
        queue_word(CMD_DRESP, $urandom, rnd_usec(1'b1),
                   stamp_sec(base, span_sel), rnd_usec(full_usec));
    endtask

    task automatic random_words(input int count);
        int stop_at;
        stop_at = words_queued + count;
        while (words_queued < stop_at)
        begin
            if ($urandom_range(0, 4) != 0)
                queue_exchange();
            else
                queue_noise();
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_valid || sync_results_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_word(CMD_DRESP,  '0, '0, '0, '0);
        queue_word(CMD_DRESP,  '0, '0, SEC_TOP, USEC_TOP);
        queue_word(CMD_IGNORE, SEC_TOP, USEC_TOP, SEC_TOP, USEC_TOP);
        queue_word(CMD_SYNC,   SEC_TOP, USEC_TOP, '0, '0);
        queue_word(CMD_FOLLOW, SEC_TOP, USEC_TOP, '0, '0);
        queue_word(CMD_DRESP,  '0, '0, '0, '0);
        queue_word(CMD_SYNC,   '0, '0, SEC_TOP, USEC_TOP);
        queue_word(CMD_FOLLOW, '0, '0, SEC_TOP, USEC_TOP);
        queue_word(CMD_DRESP,  SEC_TOP, USEC_TOP, '0, '0);
        queue_word(CMD_SYNC,   32'd1000, 20'd600, '0, '0);
        queue_word(CMD_FOLLOW, 32'd1000, 20'd1001, 32'd1000, 20'd100);
        queue_word(CMD_DRESP,  '0, '0, 32'd1000, 20'd900);
        queue_word(CMD_DRESP,  '0, '0, 32'd1000, 20'd2000);
        queue_word(CMD_SYNC,   32'd5, USEC_LAST, '0, '0);
        queue_word(CMD_FOLLOW, 32'd6, '0, 32'd4, USEC_TOP);
        queue_word(CMD_DRESP,  '0, '0, 32'd5, USEC_LAST);
        queue_word(CMD_IGNORE, '0, '0, '0, '0);
        queue_word(CMD_DRESP,  '0, '0, 32'd7, 20'd12345);
        queue_word(CMD_DRESP,  '0, '0, 32'd3, USEC_TOP);
        queue_word(CMD_DRESP,  '0, '0, 32'd5, 20'd1);
        drain();

        send_style <= IDLE_LIGHT;
        recv_style <= IDLE_LIGHT;
        random_words(150);
        drain();

        send_style <= IDLE_NONE;
        recv_style <= IDLE_NONE;
        hold_req   <= 1'b1;
        random_words(90);
        drain();

        send_style <= IDLE_HEAVY;
        recv_style <= IDLE_HEAVY;
        random_words(120);
        drain();

        send_style <= IDLE_NONE;
        recv_style <= IDLE_HEAVY;
        random_words(90);
        drain();

        send_style <= IDLE_HEAVY;
        recv_style <= IDLE_NONE;
        random_words(80);
        drain();

        repeat (TAIL_WAIT) @(negedge clk);
        if (sync_results_due.size() != 0)
            flag_error($sformatf("%0d results never arrived", sync_results_due.size()));
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #800000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
src/podavg_pkg.sv
src/podavg_front.sv
src/podavg_cdiv.sv
src/podavg_window.sv
src/podavg_skid.sv
src/ptp_offset_delay_averager_top.sv
src/podavg_chk.sv
tb/tb.sv
